>>> sv/elx_pkg.sv
// Shared types and constants for the expression lexer.
package elx_pkg;

  localparam int MAX_LEN     = 1024;
  localparam int POS_W       = $clog2(MAX_LEN + 1);
  localparam int CHAR_W      = 8;
  localparam int KIND_W      = 5;
  localparam int START_W     = 10;
  localparam int LEN_W       = 11;
  localparam int START_MAX   = 1023;
  localparam int LEN_MAX     = 2047;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [KIND_W-1:0] {
    K_AND, K_OR, K_EQ, K_NE, K_NOT, K_LE, K_LT, K_GE, K_GT,
    K_ADD, K_SUB, K_MUL, K_DIV, K_POW, K_OPEN, K_CLOSE, K_COMMA,
    K_NUMBER, K_IDENT, K_BADCHAR, K_NODIGIT, K_TOOLONG
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [START_W-1:0] start;
    logic [LEN_W-1:0]   len;
  } token_t;

  // One input item's results: tok0 first, tok1 only when two is set.
  typedef struct packed {
    token_t tok0;
    token_t tok1;
    logic   two;
  } run_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

>>> sv/elx_if.sv
// Handshake channels for characters in and tokens out.
interface elx_in_if;
  logic                       valid;
  logic                       ready;
  logic [elx_pkg::CHAR_W-1:0] char_code;
  logic                       end_of_expr;

  modport source(output valid, char_code, end_of_expr, input ready);
  modport sink(input valid, char_code, end_of_expr, output ready);
endinterface

interface elx_out_if;
  logic                        valid;
  logic                        ready;
  logic [elx_pkg::KIND_W-1:0]  token_kind;
  logic [elx_pkg::START_W-1:0] token_start;
  logic [elx_pkg::LEN_W-1:0]   token_length;
  logic                        last_in_run;

  modport source(output valid, token_kind, token_start, token_length, last_in_run,
                 input ready);
  modport sink(input valid, token_kind, token_start, token_length, last_in_run,
               output ready);
endinterface

>>> sv/elx_front.sv
// Lexer front end: takes one character per cycle while the run queue is not full and builds its run of tokens.
module elx_front (
  input  logic                 clk,
  input  logic                 rst,
  elx_in_if.sink               in_ch,
  input  elx_pkg::q_status_t   q_status,
  output logic                 push,
  output elx_pkg::run_t        run
);

  typedef enum logic [3:0] {
    M_IDLE, M_NUM_INT, M_NUM_POINT, M_NUM_FRAC, M_NUM_EXP, M_NUM_ESIGN,
    M_NUM_EDIG, M_IDENT, M_BANG, M_LT, M_GT, M_ERROR
  } mode_t;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_E_LO  = 8'h65;
  localparam logic [7:0] CH_E_UP  = 8'h45;
  localparam logic [7:0] CH_BAR   = 8'h7C;

  localparam int POS_W = elx_pkg::POS_W;

  function automatic logic [elx_pkg::START_W-1:0] sat_start(logic [POS_W-1:0] p);
    if (32'(p) > 32'(elx_pkg::START_MAX)) return elx_pkg::START_W'(elx_pkg::START_MAX);
    return elx_pkg::START_W'(p);
  endfunction

  function automatic logic [elx_pkg::LEN_W-1:0] sat_len(logic [POS_W-1:0] v);
    if (32'(v) > 32'(elx_pkg::LEN_MAX)) return elx_pkg::LEN_W'(elx_pkg::LEN_MAX);
    return elx_pkg::LEN_W'(v);
  endfunction

  function automatic elx_pkg::token_t mk_tok(elx_pkg::kind_t k, logic [POS_W-1:0] s,
                                             logic [elx_pkg::LEN_W-1:0] l);
    elx_pkg::token_t t;
    t.kind  = k;
    t.start = sat_start(s);
    t.len   = l;
    return t;
  endfunction

  mode_t            mode, mode_next;
  logic [POS_W-1:0] pos, pos_next;
  logic [POS_W-1:0] pstart, pstart_next;
  logic             opened, opened_next;

  logic [7:0] c;
  logic       accept;
  logic       is_digit, is_letter, is_blank, is_exp;

  // Fresh-start classification of the current character.
  logic           op_v;
  elx_pkg::kind_t op_kind;
  mode_t          idle_mode;
  logic           bad;

  // Pending token as it would be flushed at the current position.
  logic            flush_v, flush_err;
  elx_pkg::token_t flush_tok;
  elx_pkg::kind_t  pair_kind;

  logic            pre_v, mid_v, post_v, fresh, idle_go;
  elx_pkg::token_t pre_tok, mid_tok, post_tok;

  assign c         = in_ch.char_code;
  assign in_ch.ready = !q_status.full;
  assign accept    = in_ch.valid && in_ch.ready;
  assign is_digit  = (c >= 8'h30) && (c <= 8'h39);
  assign is_letter = ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
                     (c == CH_UNDER);
  assign is_blank  = (c == CH_TAB) || (c == CH_LF) || (c == CH_CR) || (c == CH_SPACE);
  assign is_exp    = (c == CH_E_LO) || (c == CH_E_UP);

  always_comb begin
    op_v    = 1'b1;
    op_kind = elx_pkg::K_AND;
    unique case (c)
      CH_AMP:   op_kind = elx_pkg::K_AND;
      CH_BAR:   op_kind = elx_pkg::K_OR;
      CH_EQ:    op_kind = elx_pkg::K_EQ;
      CH_PLUS:  op_kind = elx_pkg::K_ADD;
      CH_MINUS: op_kind = elx_pkg::K_SUB;
      CH_STAR:  op_kind = elx_pkg::K_MUL;
      CH_SLASH: op_kind = elx_pkg::K_DIV;
      CH_CARET: op_kind = elx_pkg::K_POW;
      CH_LPAR:  op_kind = elx_pkg::K_OPEN;
      CH_RPAR:  op_kind = elx_pkg::K_CLOSE;
      CH_COMMA: op_kind = elx_pkg::K_COMMA;
      default:  op_v = 1'b0;
    endcase

    bad = 1'b0;
    if (op_v)                 idle_mode = M_IDLE;
    else if (c == CH_BANG)    idle_mode = M_BANG;
    else if (c == CH_LT)      idle_mode = M_LT;
    else if (c == CH_GT)      idle_mode = M_GT;
    else if (is_digit)        idle_mode = M_NUM_INT;
    else if (c == CH_POINT)   idle_mode = M_NUM_POINT;
    else if (is_letter)       idle_mode = M_IDENT;
    else if (is_blank)        idle_mode = M_IDLE;
    else begin
      idle_mode = M_ERROR;
      bad       = 1'b1;
    end
  end

  always_comb begin
    flush_v   = 1'b1;
    flush_err = 1'b0;
    flush_tok = mk_tok(elx_pkg::K_NUMBER, pstart, sat_len(pos - pstart));
    pair_kind = elx_pkg::K_NE;
    unique case (mode) inside
      M_NUM_INT, M_NUM_FRAC, M_NUM_EXP, M_NUM_ESIGN, M_NUM_EDIG: ;
      M_NUM_POINT: begin
        flush_tok = mk_tok(elx_pkg::K_NODIGIT, pstart, sat_len(pos - pstart));
        flush_err = 1'b1;
      end
      M_IDENT: flush_tok = mk_tok(elx_pkg::K_IDENT, pstart, sat_len(pos - pstart));
      M_BANG:  flush_tok = mk_tok(elx_pkg::K_NOT, pstart, elx_pkg::LEN_W'(1));
      M_LT: begin
        flush_tok = mk_tok(elx_pkg::K_LT, pstart, elx_pkg::LEN_W'(1));
        pair_kind = elx_pkg::K_LE;
      end
      M_GT: begin
        flush_tok = mk_tok(elx_pkg::K_GT, pstart, elx_pkg::LEN_W'(1));
        pair_kind = elx_pkg::K_GE;
      end
      default: flush_v = 1'b0;
    endcase
  end

  always_comb begin
    mode_next   = mode;
    pos_next    = pos;
    pstart_next = pstart;
    opened_next = opened;
    pre_v       = 1'b0;
    mid_v       = 1'b0;
    post_v      = 1'b0;
    fresh       = 1'b0;
    idle_go     = 1'b0;
    pre_tok     = mk_tok(elx_pkg::K_OPEN, '0, '0);
    mid_tok     = flush_tok;
    post_tok    = mk_tok(elx_pkg::K_CLOSE, pos, '0);

    if (accept) begin
      if (in_ch.end_of_expr) begin
        if (mode != M_ERROR) begin
          pre_v  = !opened;
          mid_v  = flush_v;
          post_v = !flush_err;
        end
        mode_next   = M_IDLE;
        pos_next    = '0;
        pstart_next = '0;
        opened_next = 1'b0;
      end else if (mode != M_ERROR) begin
        pre_v       = !opened;
        opened_next = 1'b1;
        if (pos >= POS_W'(elx_pkg::MAX_LEN)) begin
          // Drop any pending token and report the overflow.
          mid_v     = 1'b1;
          mid_tok   = mk_tok(elx_pkg::K_TOOLONG, pos, '0);
          mode_next = M_ERROR;
        end else begin
          pos_next = pos + 1'b1;
          unique case (mode) inside
            M_NUM_INT: begin
              if (c == CH_POINT)  mode_next = M_NUM_POINT;
              else if (is_exp)    mode_next = M_NUM_EXP;
              else if (!is_digit) fresh = 1'b1;
            end
            M_NUM_POINT: begin
              if (is_digit) mode_next = M_NUM_FRAC;
              else begin
                mid_v     = 1'b1;
                mode_next = M_ERROR;
              end
            end
            M_NUM_FRAC: begin
              if (is_exp)         mode_next = M_NUM_EXP;
              else if (!is_digit) fresh = 1'b1;
            end
            M_NUM_EXP: begin
              if ((c == CH_PLUS) || (c == CH_MINUS)) mode_next = M_NUM_ESIGN;
              else if (is_digit)                     mode_next = M_NUM_EDIG;
              else                                   fresh = 1'b1;
            end
            M_NUM_ESIGN, M_NUM_EDIG: begin
              if (is_digit) mode_next = M_NUM_EDIG;
              else          fresh = 1'b1;
            end
            M_IDENT: begin
              if (!(is_letter || is_digit)) fresh = 1'b1;
            end
            M_BANG, M_LT, M_GT: begin
              if (c == CH_EQ) begin
                mid_v     = 1'b1;
                mid_tok   = mk_tok(pair_kind, pstart, elx_pkg::LEN_W'(2));
                mode_next = M_IDLE;
              end else begin
                fresh = 1'b1;
              end
            end
            default: idle_go = 1'b1;
          endcase

          if (fresh) mid_v = flush_v;
          if (fresh || idle_go) begin
            post_v    = op_v || bad;
            post_tok  = mk_tok(bad ? elx_pkg::K_BADCHAR : op_kind, pos, elx_pkg::LEN_W'(1));
            mode_next = idle_mode;
            if (!op_v) pstart_next = pos;
          end
        end
      end
    end
  end

  // Pack up to two results, oldest first.
  always_comb begin
    push = pre_v || mid_v || post_v;
    if (pre_v) begin
      run.tok0 = pre_tok;
      run.tok1 = mid_v ? mid_tok : post_tok;
      run.two  = mid_v || post_v;
    end else if (mid_v) begin
      run.tok0 = mid_tok;
      run.tok1 = post_tok;
      run.two  = post_v;
    end else begin
      run.tok0 = post_tok;
      run.tok1 = post_tok;
      run.two  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= M_IDLE;
      pos    <= '0;
      pstart <= '0;
      opened <= 1'b0;
    end else begin
      mode   <= mode_next;
      pos    <= pos_next;
      pstart <= pstart_next;
      opened <= opened_next;
    end
  end

endmodule

>>> sv/elx_queue.sv
// Short queue of token runs between the lexer front end and the output side.
module elx_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  elx_pkg::run_t      push_run,
  input  logic               pop,
  output elx_pkg::run_t      head,
  output elx_pkg::q_status_t status
);

  elx_pkg::run_t                entries [elx_pkg::QUEUE_DEPTH];
  logic [elx_pkg::QPTR_W-1:0]   wr_ptr, rd_ptr;
  logic [elx_pkg::QCNT_W-1:0]   count;

  assign status.full  = (count == elx_pkg::QCNT_W'(elx_pkg::QUEUE_DEPTH));
  assign status.empty = (count == '0);
  assign head         = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_run;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

>>> sv/elx_back.sv
// Output side: splits each run into single tokens behind an output register.
module elx_back (
  input  logic               clk,
  input  logic               rst,
  input  elx_pkg::run_t      head,
  input  elx_pkg::q_status_t q_status,
  output logic               pop,
  elx_out_if.source          out_ch
);

  logic            out_valid;
  elx_pkg::token_t out_tok;
  logic            out_last;
  logic            sub;
  logic            load;

  assign load = !q_status.empty && (!out_valid || out_ch.ready);
  // Release the run once its final token moves into the output register.
  assign pop  = load && (sub || !head.two);

  assign out_ch.valid        = out_valid;
  assign out_ch.token_kind   = out_tok.kind;
  assign out_ch.token_start  = out_tok.start;
  assign out_ch.token_length = out_tok.len;
  assign out_ch.last_in_run  = out_last;

  always_ff @(posedge clk) begin
    if (load) begin
      out_tok  <= sub ? head.tok1 : head.tok0;
      out_last <= sub || !head.two;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sub       <= 1'b0;
    end else begin
      if (load)              out_valid <= 1'b1;
      else if (out_ch.ready) out_valid <= 1'b0;
      if (load) sub <= head.two && !sub;
    end
  end

endmodule

>>> sv/expression_lexer.sv
// Top level: a character in per cycle while the run queue has room, token events out, a run queue between.
// The first token of an item is shown once it has passed the run queue entry and the output register.
// Throughput: one character per cycle while each gives at most one token and the
// output is ready; the output register drains one token per cycle when not stalled,
// and the four-entry run queue absorbs the second token of a two-token item.
// Reset: synchronous, clears lexer state, queue pointers and the output valid.
module expression_lexer (
  input  logic      clk,
  input  logic      rst,
  elx_in_if.sink    in_ch,
  elx_out_if.source out_ch
);

  elx_pkg::q_status_t q_status;
  elx_pkg::run_t      push_run;
  elx_pkg::run_t      head;
  logic               push;
  logic               pop;

  elx_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_ch    (in_ch),
    .q_status (q_status),
    .push     (push),
    .run      (push_run)
  );

  elx_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_run (push_run),
    .pop      (pop),
    .head     (head),
    .status   (q_status)
  );

  elx_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .q_status (q_status),
    .pop      (pop),
    .out_ch   (out_ch)
  );

endmodule

>>> sv/elx_checker.sv
// Port-level checks on the lexer outputs, bound to the top level.
module elx_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [elx_pkg::KIND_W-1:0]  token_kind,
  input logic [elx_pkg::START_W-1:0] token_start,
  input logic [elx_pkg::LEN_W-1:0]   token_length,
  input logic                        last_in_run
);

  // A stalled request keeps its token.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(token_kind) &&
      $stable(token_start) && $stable(token_length) && $stable(last_in_run))
    else $error("token changed while stalled");

  a_no_valid_after_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

  a_pair_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && (token_kind == elx_pkg::K_NE || token_kind == elx_pkg::K_LE ||
                  token_kind == elx_pkg::K_GE) |-> token_length == elx_pkg::LEN_W'(2))
    else $error("two-character comparison with wrong length");

  // Errors end a run: nothing follows them for the same character.
  a_error_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (token_kind == elx_pkg::K_BADCHAR || token_kind == elx_pkg::K_NODIGIT ||
                  token_kind == elx_pkg::K_TOOLONG) |-> last_in_run)
    else $error("error token not last in its run");

endmodule

bind expression_lexer elx_checker u_elx_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .token_kind   (out_ch.token_kind),
  .token_start  (out_ch.token_start),
  .token_length (out_ch.token_length),
  .last_in_run  (out_ch.last_in_run)
);
